// File: rtl/pcs_pkg.sv
// Shared types, widths and codes for the Pearson correlation block.
package pcs_pkg;

    // Sample and accumulator widths
    localparam int SAMPLE_W = 24;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 36;
    localparam int SQ_W     = 59;
    localparam int CROSS_W  = 60;

    // Output widths
    localparam int CORR_W   = 32;
    localparam int PVAL_W   = 31;
    localparam int BOUND_W  = 32;

    // Width of the shared serial arithmetic unit and its square root
    localparam int WIDE_W   = 128;
    localparam int ROOT_W   = WIDE_W / 2;

    // Pairs held per set; later pairs of a set are dropped
    localparam int MAX_PAIRS = 4096;

    // Default depth of the set queue between front and back
    localparam int PCS_QUEUE_DEPTH = 2;

    // Fixed-point constants
    localparam logic [PVAL_W-1:0] ONE_Q30 = PVAL_W'(1073741824);
    localparam logic [PVAL_W-1:0] P_FLOOR = PVAL_W'(1073742);

    // Closed set handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic signed [SUM_W-1:0]   sum_pred;
        logic signed [SUM_W-1:0]   sum_out;
        logic [SQ_W-1:0]           sum_pred_sq;
        logic [SQ_W-1:0]           sum_out_sq;
        logic signed [CROSS_W-1:0] sum_cross;
    } t_set;

    // Operations of the serial arithmetic unit
    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FULL     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FEW      = 3'd2,
        ST_ZERO_VAR = 3'd3,
        ST_SAT      = 3'd4
    } t_status;

    // Back-end sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_AXX,
        S_SX2,
        S_BYY,
        S_SY2,
        S_CXY,
        S_SXY,
        S_NA,
        S_QA,
        S_NB,
        S_QB,
        S_DEN,
        S_QR,
        S_SIG,
        S_R2,
        S_NUM,
        S_T2,
        S_TQ,
        S_T3,
        S_HW,
        S_HWD,
        S_HWQ,
        S_DONE
    } t_fin_state;

endpackage

// File: rtl/pcs_front.sv
// Front end: accepts sample pairs, forms products and keeps the running sums.
module pcs_front
    import pcs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_prediction,
    input  logic signed [SAMPLE_W-1:0] i_outcome,
    input  logic                       i_last_pair,
    input  logic                       i_empty_set,
    output logic                       o_push,
    output t_set                       o_set,
    input  logic                       i_queue_ready
);

    localparam int PROD_W = 2 * SAMPLE_W;

    logic                       r_s1_valid;
    logic                       r_s1_add;
    logic                       r_s1_close;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic [PROD_W-2:0]          r_xx;
    logic [PROD_W-2:0]          r_yy;
    logic signed [PROD_W-1:0]   r_xy;

    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sum_pred;
    logic signed [SUM_W-1:0]    r_sum_out;
    logic [SQ_W-1:0]            r_sum_pred_sq;
    logic [SQ_W-1:0]            r_sum_out_sq;
    logic signed [CROSS_W-1:0]  r_sum_cross;

    logic signed [PROD_W-1:0]   xx_full;
    logic signed [PROD_W-1:0]   yy_full;
    logic signed [PROD_W-1:0]   xy_full;
    logic                       in_acc;
    logic                       s2_adv;
    logic                       add_ok;
    t_set                       nx;

    // Stage 1 products
    assign xx_full = i_prediction * i_prediction;
    assign yy_full = i_outcome * i_outcome;
    assign xy_full = i_prediction * i_outcome;

    // Stage 2 advances unless a closing transaction meets a full queue
    assign s2_adv     = r_s1_valid && (!r_s1_close || i_queue_ready);
    assign o_in_ready = !r_s1_valid || s2_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign add_ok     = r_s1_add && (r_count < CNT_W'(MAX_PAIRS));

    // Sums including the pair in stage 2
    always_comb begin
        nx = '{count: r_count, sum_pred: r_sum_pred, sum_out: r_sum_out,
               sum_pred_sq: r_sum_pred_sq, sum_out_sq: r_sum_out_sq,
               sum_cross: r_sum_cross};
        if (add_ok) begin
            nx.count       = r_count + CNT_W'(1);
            nx.sum_pred    = r_sum_pred + SUM_W'(r_x);
            nx.sum_out     = r_sum_out + SUM_W'(r_y);
            nx.sum_pred_sq = r_sum_pred_sq + SQ_W'(r_xx);
            nx.sum_out_sq  = r_sum_out_sq + SQ_W'(r_yy);
            nx.sum_cross   = r_sum_cross + CROSS_W'(r_xy);
        end
    end

    assign o_push = r_s1_valid && r_s1_close && i_queue_ready;
    assign o_set  = nx;

    // Stage 1 occupancy and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_count       <= '0;
            r_sum_pred    <= '0;
            r_sum_out     <= '0;
            r_sum_pred_sq <= '0;
            r_sum_out_sq  <= '0;
            r_sum_cross   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_adv) begin
                if (r_s1_close) begin
                    r_count       <= '0;
                    r_sum_pred    <= '0;
                    r_sum_out     <= '0;
                    r_sum_pred_sq <= '0;
                    r_sum_out_sq  <= '0;
                    r_sum_cross   <= '0;
                end else begin
                    r_count       <= nx.count;
                    r_sum_pred    <= nx.sum_pred;
                    r_sum_out     <= nx.sum_out;
                    r_sum_pred_sq <= nx.sum_pred_sq;
                    r_sum_out_sq  <= nx.sum_out_sq;
                    r_sum_cross   <= nx.sum_cross;
                end
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_add   <= !i_empty_set;
            r_s1_close <= i_last_pair || i_empty_set;
            r_x        <= i_prediction;
            r_y        <= i_outcome;
            r_xx       <= xx_full[PROD_W-2:0];
            r_yy       <= yy_full[PROD_W-2:0];
            r_xy       <= xy_full;
        end
    end

endmodule

// File: rtl/pcs_fifo.sv
// Short queue of closed sets between the front and back ends.
module pcs_fifo
    import pcs_pkg::*;
#(
    parameter int DEPTH = PCS_QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_set i_data,
    output logic o_ready,
    output logic o_valid,
    output t_set o_data,
    input  logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_set          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_fill;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_fill != CW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/pcs_arith.sv
// Shared serial arithmetic unit: multiply, divide and square root, one bit a cycle.
module pcs_arith
    import pcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_arith_req        i_req,
    input  logic [WIDE_W-1:0] i_opa,
    input  logic [WIDE_W-1:0] i_opb,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_result
);

    localparam int CNT_BITS = $clog2(WIDE_W);
    localparam int SQ_REM_W = ROOT_W + 4;

    logic                r_busy;
    logic                r_done;
    t_arith_op           r_op;
    logic [CNT_BITS-1:0] r_cnt;
    logic [WIDE_W-1:0]   r_x;
    logic [WIDE_W-1:0]   r_y;
    logic [WIDE_W-1:0]   r_acc;
    logic [ROOT_W-1:0]   r_root;

    logic [WIDE_W-1:0]   div_rem;
    logic                div_ge;
    logic [SQ_REM_W-1:0] sq_rem;
    logic [SQ_REM_W-1:0] sq_trial;
    logic                sq_ge;

    // Restoring division step: shift in one numerator bit
    assign div_rem  = {r_acc[WIDE_W-2:0], r_x[WIDE_W-1]};
    assign div_ge   = (div_rem >= r_y);

    // Digit-by-digit square root step: bring down two radicand bits
    assign sq_rem   = {r_acc[SQ_REM_W-3:0], r_x[WIDE_W-1:WIDE_W-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_rem >= sq_trial);

    assign o_done = r_done;

    always_comb begin
        case (r_op)
            AOP_MUL:  o_result = r_acc;
            AOP_DIV:  o_result = r_x;
            AOP_SQRT: o_result = WIDE_W'(r_root);
            default:  o_result = r_acc;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_cnt  <= (i_req.op == AOP_DIV) ? CNT_BITS'(WIDE_W - 1) : CNT_BITS'(ROOT_W - 1);
            r_x    <= i_opa;
            r_y    <= i_opb;
            r_acc  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            case (r_op)
                AOP_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end
                AOP_DIV: begin
                    r_acc <= div_ge ? (div_rem - r_y) : div_rem;
                    r_x   <= {r_x[WIDE_W-2:0], div_ge};
                end
                AOP_SQRT: begin
                    r_acc  <= WIDE_W'(sq_ge ? (sq_rem - sq_trial) : sq_rem);
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_x    <= r_x << 2;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

endmodule

// File: rtl/pcs_back.sv
// Back end: sequences the per-set arithmetic and holds the result register.
module pcs_back
    import pcs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_set_valid,
    input  t_set                      i_set,
    output logic                      o_set_pop,
    output t_arith_req                o_req,
    output logic [WIDE_W-1:0]         o_opa,
    output logic [WIDE_W-1:0]         o_opb,
    input  logic                      i_arith_done,
    input  logic [WIDE_W-1:0]         i_arith_result,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [CORR_W-1:0]  o_correlation,
    output logic [PVAL_W-1:0]         o_p_value,
    output logic signed [BOUND_W-1:0] o_interval_low,
    output logic signed [BOUND_W-1:0] o_interval_high,
    output logic [CNT_W-1:0]          o_pair_count,
    output logic [2:0]                o_status
);

    localparam int OM_W  = 61;
    localparam int HWD_W = 23;
    // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [WIDE_W-1:0] RECIP3 = WIDE_W'(64'hAAAA_AAAB);

    t_fin_state          r_state, n_state;
    t_set                r_set, n_set;
    logic [WIDE_W-1:0]   r_p1, n_p1;
    logic [WIDE_W-1:0]   r_a, n_a;
    logic [WIDE_W-1:0]   r_b, n_b;
    logic [WIDE_W-1:0]   r_cm, n_cm;
    logic [ROOT_W-1:0]   r_sa, n_sa;
    logic [OM_W-1:0]     r_om, n_om;
    logic [PVAL_W-1:0]   r_rmag, n_rmag;
    logic                r_rneg, n_rneg;
    logic                r_zero, n_zero;
    logic                r_sat, n_sat;
    t_status             r_status, n_status;
    logic [PVAL_W-1:0]   r_p, n_p;
    logic [BOUND_W-1:0]  r_lo, n_lo;
    logic [BOUND_W-1:0]  r_hi, n_hi;
    logic                r_out_valid, n_out_valid;
    logic [CORR_W-1:0]   r_o_corr, n_o_corr;
    logic [PVAL_W-1:0]   r_o_p, n_o_p;
    logic [BOUND_W-1:0]  r_o_lo, n_o_lo;
    logic [BOUND_W-1:0]  r_o_hi, n_o_hi;
    logic [CNT_W-1:0]    r_o_count, n_o_count;
    t_status             r_o_status, n_o_status;

    logic [WIDE_W-1:0]   res;
    logic [SUM_W-1:0]    mag_sp;
    logic [SUM_W-1:0]    mag_so;
    logic [CROSS_W-1:0]  mag_sc;
    logic [WIDE_W-1:0]   c_val;
    logic [WIDE_W-1:0]   om9;
    logic [HWD_W-1:0]    hw_den;
    logic [BOUND_W+1:0]  r28;
    logic [BOUND_W+1:0]  hw34;
    logic [BOUND_W-1:0]  p_calc;

    assign res    = i_arith_result;
    assign mag_sp = r_set.sum_pred[SUM_W-1] ? SUM_W'(-r_set.sum_pred) : SUM_W'(r_set.sum_pred);
    assign mag_so = r_set.sum_out[SUM_W-1] ? SUM_W'(-r_set.sum_out) : SUM_W'(r_set.sum_out);
    assign mag_sc = r_set.sum_cross[CROSS_W-1] ? CROSS_W'(-r_set.sum_cross)
                                               : CROSS_W'(r_set.sum_cross);

    // C = n*Sxy - Sx*Sy from the signed partial products
    assign c_val  = r_p1 - ((r_set.sum_pred[SUM_W-1] != r_set.sum_out[SUM_W-1]) ? -res : res);
    assign om9    = (WIDE_W'(r_om) << 3) + WIDE_W'(r_om);
    assign hw_den = HWD_W'(r_set.count - CNT_W'(3)) * HWD_W'(625);
    assign r28    = r_rneg ? -(BOUND_W+2)'(r_rmag >> 2) : (BOUND_W+2)'(r_rmag >> 2);
    assign hw34   = (BOUND_W+2)'(res[BOUND_W-1:0]);
    assign p_calc = BOUND_W'(ONE_Q30) - res[BOUND_W+32:33];

    assign o_out_valid     = r_out_valid;
    assign o_correlation   = r_o_corr;
    assign o_p_value       = r_o_p;
    assign o_interval_low  = r_o_lo;
    assign o_interval_high = r_o_hi;
    assign o_pair_count    = r_o_count;
    assign o_status        = r_o_status;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_set       = r_set;
        n_p1        = r_p1;
        n_a         = r_a;
        n_b         = r_b;
        n_cm        = r_cm;
        n_sa        = r_sa;
        n_om        = r_om;
        n_rmag      = r_rmag;
        n_rneg      = r_rneg;
        n_zero      = r_zero;
        n_sat       = r_sat;
        n_status    = r_status;
        n_p         = r_p;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_o_corr    = r_o_corr;
        n_o_p       = r_o_p;
        n_o_lo      = r_o_lo;
        n_o_hi      = r_o_hi;
        n_o_count   = r_o_count;
        n_o_status  = r_o_status;
        o_set_pop   = 1'b0;
        o_req       = '{start: 1'b0, op: AOP_MUL};
        o_opa       = '0;
        o_opb       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_set_valid) begin
                    o_set_pop = 1'b1;
                    n_set     = i_set;
                    n_sat     = 1'b0;
                    n_rneg    = 1'b0;
                    n_rmag    = '0;
                    n_zero    = 1'b0;
                    if (i_set.count == '0) begin
                        n_p      = ONE_Q30;
                        n_lo     = '0;
                        n_hi     = '0;
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        o_req   = '{start: 1'b1, op: AOP_MUL};
                        o_opa   = WIDE_W'(i_set.count);
                        o_opb   = WIDE_W'(i_set.sum_pred_sq);
                        n_state = S_AXX;
                    end
                end
            end
            // A = n*Sxx - Sx^2
            S_AXX: begin
                if (i_arith_done) begin
                    n_p1    = res;
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(mag_sp);
                    o_opb   = WIDE_W'(mag_sp);
                    n_state = S_SX2;
                end
            end
            S_SX2: begin
                if (i_arith_done) begin
                    n_a     = r_p1 - res;
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(r_set.count);
                    o_opb   = WIDE_W'(r_set.sum_out_sq);
                    n_state = S_BYY;
                end
            end
            // B = n*Syy - Sy^2
            S_BYY: begin
                if (i_arith_done) begin
                    n_p1    = res;
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(mag_so);
                    o_opb   = WIDE_W'(mag_so);
                    n_state = S_SY2;
                end
            end
            S_SY2: begin
                if (i_arith_done) begin
                    n_b     = r_p1 - res;
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(r_set.count);
                    o_opb   = WIDE_W'(mag_sc);
                    n_state = S_CXY;
                end
            end
            // C = n*Sxy - Sx*Sy
            S_CXY: begin
                if (i_arith_done) begin
                    n_p1    = r_set.sum_cross[CROSS_W-1] ? -res : res;
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(mag_sp);
                    o_opb   = WIDE_W'(mag_so);
                    n_state = S_SXY;
                end
            end
            S_SXY: begin
                if (i_arith_done) begin
                    n_rneg = c_val[WIDE_W-1];
                    n_cm   = c_val[WIDE_W-1] ? -c_val : c_val;
                    n_zero = (r_a == '0) || (r_b == '0);
                    if ((r_a == '0) || (r_b == '0)) begin
                        n_rneg  = 1'b0;
                        n_rmag  = '0;
                        n_state = S_SIG;
                    end else begin
                        n_state = S_NA;
                    end
                end
            end
            // Normalise A by even shifts; C follows by half the shift
            S_NA: begin
                if (r_a[WIDE_W-3:WIDE_W-4] == 2'b00) begin
                    n_a  = r_a << 2;
                    n_cm = r_cm << 1;
                end else begin
                    o_req   = '{start: 1'b1, op: AOP_SQRT};
                    o_opa   = r_a;
                    n_state = S_QA;
                end
            end
            S_QA: begin
                if (i_arith_done) begin
                    n_sa    = res[ROOT_W-1:0];
                    n_state = S_NB;
                end
            end
            S_NB: begin
                if (r_b[WIDE_W-3:WIDE_W-4] == 2'b00) begin
                    n_b  = r_b << 2;
                    n_cm = r_cm << 1;
                end else begin
                    o_req   = '{start: 1'b1, op: AOP_SQRT};
                    o_opa   = r_b;
                    n_state = S_QB;
                end
            end
            S_QB: begin
                if (i_arith_done) begin
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(r_sa);
                    o_opb   = res;
                    n_state = S_DEN;
                end
            end
            // |r| = |C| / (sqrt(A)*sqrt(B) >> 30)
            S_DEN: begin
                if (i_arith_done) begin
                    o_req   = '{start: 1'b1, op: AOP_DIV};
                    o_opa   = r_cm;
                    o_opb   = res >> 30;
                    n_state = S_QR;
                end
            end
            S_QR: begin
                if (i_arith_done) begin
                    n_rmag  = (res > WIDE_W'(ONE_Q30)) ? ONE_Q30 : res[PVAL_W-1:0];
                    n_rneg  = r_rneg && (res != '0);
                    n_state = S_SIG;
                end
            end
            // Significance
            S_SIG: begin
                n_status = r_zero ? ST_ZERO_VAR
                                  : ((r_set.count <= CNT_W'(2)) ? ST_FEW : ST_FULL);
                if (r_set.count <= CNT_W'(2)) begin
                    n_p     = ONE_Q30;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_state = S_DONE;
                end else if (r_rmag >= ONE_Q30) begin
                    n_p     = P_FLOOR;
                    n_sat   = 1'b1;
                    n_state = S_HW;
                end else begin
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = WIDE_W'(r_rmag);
                    o_opb   = WIDE_W'(r_rmag);
                    n_state = S_R2;
                end
            end
            S_R2: begin
                if (i_arith_done) begin
                    n_om    = {1'b1, {(OM_W-1){1'b0}}} - res[OM_W-1:0];
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = res;
                    o_opb   = WIDE_W'(r_set.count - CNT_W'(2));
                    n_state = S_NUM;
                end
            end
            // |t| >= 3 floors p at once
            S_NUM: begin
                if (i_arith_done) begin
                    if (res >= om9) begin
                        n_p     = P_FLOOR;
                        n_state = S_HW;
                    end else begin
                        o_req   = '{start: 1'b1, op: AOP_DIV};
                        o_opa   = {res[WIDE_W-61:0], 60'd0};
                        o_opb   = WIDE_W'(r_om);
                        n_state = S_T2;
                    end
                end
            end
            S_T2: begin
                if (i_arith_done) begin
                    o_req   = '{start: 1'b1, op: AOP_SQRT};
                    o_opa   = res;
                    n_state = S_TQ;
                end
            end
            // |t|/3 by reciprocal multiplication; |t| < 3.0 keeps it within 32 bits
            S_TQ: begin
                if (i_arith_done) begin
                    o_req   = '{start: 1'b1, op: AOP_MUL};
                    o_opa   = res;
                    o_opb   = RECIP3;
                    n_state = S_T3;
                end
            end
            S_T3: begin
                if (i_arith_done) begin
                    n_p     = (p_calc < BOUND_W'(P_FLOOR)) ? P_FLOOR : p_calc[PVAL_W-1:0];
                    n_state = S_HW;
                end
            end
            // Half width 1.96/sqrt(n-3) in Q28
            S_HW: begin
                if (r_set.count == CNT_W'(3)) begin
                    n_lo    = {1'b1, {(BOUND_W-1){1'b0}}};
                    n_hi    = {1'b0, {(BOUND_W-1){1'b1}}};
                    n_sat   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_req   = '{start: 1'b1, op: AOP_DIV};
                    o_opa   = WIDE_W'(2401) << 56;
                    o_opb   = WIDE_W'(hw_den);
                    n_state = S_HWD;
                end
            end
            S_HWD: begin
                if (i_arith_done) begin
                    o_req   = '{start: 1'b1, op: AOP_SQRT};
                    o_opa   = res;
                    n_state = S_HWQ;
                end
            end
            S_HWQ: begin
                if (i_arith_done) begin
                    n_lo    = BOUND_W'(r28 - hw34);
                    n_hi    = BOUND_W'(r28 + hw34);
                    n_state = S_DONE;
                end
            end
            // Load the result register once it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_corr    = r_rneg ? -CORR_W'(r_rmag) : CORR_W'(r_rmag);
                    n_o_p       = r_p;
                    n_o_lo      = r_lo;
                    n_o_hi      = r_hi;
                    n_o_count   = r_set.count;
                    n_o_status  = (r_sat && (r_status == ST_FULL)) ? ST_SAT : r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_set      <= n_set;
        r_p1       <= n_p1;
        r_a        <= n_a;
        r_b        <= n_b;
        r_cm       <= n_cm;
        r_sa       <= n_sa;
        r_om       <= n_om;
        r_rmag     <= n_rmag;
        r_rneg     <= n_rneg;
        r_zero     <= n_zero;
        r_sat      <= n_sat;
        r_status   <= n_status;
        r_p        <= n_p;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_o_corr   <= n_o_corr;
        r_o_p      <= n_o_p;
        r_o_lo     <= n_o_lo;
        r_o_hi     <= n_o_hi;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
    end

endmodule

// File: rtl/pearson_correlation_significance.sv
// Top level of the Pearson correlation and significance block.
//
//  Channel  Handshake                Payload
//  in       i_in_valid / o_in_ready  i_prediction, i_outcome, i_last_pair, i_empty_set
//  out      o_out_valid / i_out_ready o_correlation, o_p_value, o_interval_low,
//                                    o_interval_high, o_pair_count, o_status
//
// Pairs are taken one per cycle unless stalled; products are registered, then summed.
// A closing transaction pushes the sums into the set queue; the back end then takes
// one set at a time and works it through the shared serial multiply/divide/root unit
// one operation at a time, normalising A and B by shifts before their square roots.
// Reset is synchronous and active low; no clearing pass is needed.
// The front stalls only when a closing transaction finds the set queue full.
module pearson_correlation_significance
    import pcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = PCS_QUEUE_DEPTH
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_prediction,
    input  logic signed [SAMPLE_W-1:0] i_outcome,
    input  logic                       i_last_pair,
    input  logic                       i_empty_set,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [CORR_W-1:0]   o_correlation,
    output logic [PVAL_W-1:0]          o_p_value,
    output logic signed [BOUND_W-1:0]  o_interval_low,
    output logic signed [BOUND_W-1:0]  o_interval_high,
    output logic [CNT_W-1:0]           o_pair_count,
    output logic [2:0]                 o_status
);

    logic              push;
    t_set              push_set;
    logic              queue_ready;
    logic              queue_valid;
    t_set              queue_set;
    logic              queue_pop;
    t_arith_req        req;
    logic [WIDE_W-1:0] opa;
    logic [WIDE_W-1:0] opb;
    logic              arith_done;
    logic [WIDE_W-1:0] arith_result;

    pcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_prediction  (i_prediction),
        .i_outcome     (i_outcome),
        .i_last_pair   (i_last_pair),
        .i_empty_set   (i_empty_set),
        .o_push        (push),
        .o_set         (push_set),
        .i_queue_ready (queue_ready)
    );

    pcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_set),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_set),
        .i_pop   (queue_pop)
    );

    pcs_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_opa    (opa),
        .i_opb    (opb),
        .o_done   (arith_done),
        .o_result (arith_result)
    );

    pcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_set_valid     (queue_valid),
        .i_set           (queue_set),
        .o_set_pop       (queue_pop),
        .o_req           (req),
        .o_opa           (opa),
        .o_opb           (opb),
        .i_arith_done    (arith_done),
        .i_arith_result  (arith_result),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_correlation   (o_correlation),
        .o_p_value       (o_p_value),
        .o_interval_low  (o_interval_low),
        .o_interval_high (o_interval_high),
        .o_pair_count    (o_pair_count),
        .o_status        (o_status)
    );

endmodule
